### hdl/frda_pkg.sv
// shared constants, reset values and arctangent table for the frame relative
// direction angles unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package frda_pkg;

  localparam int CORDIC_STAGES_DEFAULT   = 16;
  localparam int COMPONENT_WIDTH_DEFAULT = 16;

  localparam int AXIS_WIDTH  = 48;
  localparam int AXIS_COMP   = 16;
  localparam int INDEX_WIDTH = 2;
  localparam int ANGLE_WIDTH = 34;
  localparam int OUT_WIDTH   = 16;
  localparam int GUARD_BITS  = 8;
  localparam int GAIN_SHIFT  = 16;

  localparam logic [INDEX_WIDTH-1:0] REG_X_AXIS = 2'd0;
  localparam logic [INDEX_WIDTH-1:0] REG_Y_AXIS = 2'd1;
  localparam logic [INDEX_WIDTH-1:0] REG_Z_AXIS = 2'd2;

  localparam logic [AXIS_WIDTH-1:0] X_AXIS_RESET = 48'h0000_0000_4000;
  localparam logic [AXIS_WIDTH-1:0] Y_AXIS_RESET = 48'h0000_4000_0000;
  localparam logic [AXIS_WIDTH-1:0] Z_AXIS_RESET = 48'h4000_0000_0000;

  localparam logic [16:0] GAIN_INV = 17'd39797;

  localparam logic signed [ANGLE_WIDTH-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [ANGLE_WIDTH-1:0] ROUND_HALF   = 34'sd32768;
  localparam logic signed [ANGLE_WIDTH-1:0] PHI_MAX      = 34'sd32767;
  localparam logic signed [ANGLE_WIDTH-1:0] PHI_MIN      = -34'sd32768;
  localparam logic signed [ANGLE_WIDTH-1:0] THETA_MAX    = 34'sd32768;
  localparam logic [OUT_WIDTH-1:0]          PI_CODE      = 16'h8000;

  // arctangent of 2^-i, 2^31 per pi, rounded to nearest
  function automatic logic signed [ANGLE_WIDTH-1:0] atan_entry(input int i);
    logic signed [ANGLE_WIDTH-1:0] v;
    case (i)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // signed component k of a packed axis
  function automatic logic signed [AXIS_COMP-1:0] axis_comp(
    input logic [AXIS_WIDTH-1:0] axis, input int k);
    logic signed [AXIS_COMP-1:0] c;
    c = $signed(axis[k*AXIS_COMP +: AXIS_COMP]);
    return c;
  endfunction

endpackage
`default_nettype wire

### hdl/frda_cordic_stage.sv
// one registered cordic vectoring micro-rotation
// depends on frda_pkg for the arctangent table
`timescale 1ns / 1ps
`default_nettype none
module frda_cordic_stage #(
  parameter int W     = 46,
  parameter int ZW    = frda_pkg::ANGLE_WIDTH,
  parameter int SHIFT = 0
) (
  input  wire logic                 clk,
  input  wire logic signed [W-1:0]  x_in,
  input  wire logic signed [W-1:0]  y_in,
  input  wire logic signed [ZW-1:0] z_in,
  output logic signed [W-1:0]       x_out,
  output logic signed [W-1:0]       y_out,
  output logic signed [ZW-1:0]      z_out
);

  localparam logic signed [ZW-1:0] ATAN = ZW'(frda_pkg::atan_entry(SHIFT));

  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;

  assign dx = y_in >>> SHIFT;
  assign dy = x_in >>> SHIFT;

  always_ff @(posedge clk) begin
    if (!y_in[W-1]) begin
      x_out <= x_in + dx;
      y_out <= y_in - dy;
      z_out <= z_in + ATAN;
    end else begin
      x_out <= x_in - dx;
      y_out <= y_in + dy;
      z_out <= z_in - ATAN;
    end
  end

endmodule
`default_nettype wire

### hdl/frame_relative_direction_angles_unit.sv
// top level: frame projection, azimuth cordic, gain removal, polar cordic
// depends on frda_pkg and frda_cordic_stage
`timescale 1ns / 1ps
`default_nettype none
// usage
//   input beat: vec_x/vec_y/vec_z taken at a rising edge with start high and
//   busy low; busy is always low, so a new vector may enter every cycle
//   configuration: wr_en with wr_index 0/1/2 writes the frame x/y/z axis
//   (three packed signed q2.14 components); other indexes are ignored.
//   write only while no vector is in flight
//   result beat: done is high for exactly one cycle with polar_angle,
//   azimuth and degenerate; the receiver cannot hold it off, and none is needed
//   result path: input reg, 9 multiplies, dot sums, pre-rotation, azimuth
//   cordic, gain multiply, gain sum/pre-rotation, polar cordic, output; each
//   of these is registered
//   throughput: one vector per cycle, set by the fully unrolled cordic stages
//   reset: axes return to the identity frame and the pipeline empties; any
//   vector in flight is dropped
//   degenerate: zero vector or vector on the frame z axis gives zero azimuth
module frame_relative_direction_angles_unit #(
  parameter int CORDIC_STAGES   = frda_pkg::CORDIC_STAGES_DEFAULT,
  parameter int COMPONENT_WIDTH = frda_pkg::COMPONENT_WIDTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [COMPONENT_WIDTH-1:0]     vec_x,
  input  wire logic signed [COMPONENT_WIDTH-1:0]     vec_y,
  input  wire logic signed [COMPONENT_WIDTH-1:0]     vec_z,
  input  wire logic                                  wr_en,
  input  wire logic [frda_pkg::INDEX_WIDTH-1:0]      wr_index,
  input  wire logic [frda_pkg::AXIS_WIDTH-1:0]       wr_data,
  output logic                                       done,
  output logic [frda_pkg::OUT_WIDTH-1:0]             polar_angle,
  output logic signed [frda_pkg::OUT_WIDTH-1:0]      azimuth,
  output logic                                       degenerate
);

  localparam int CW  = COMPONENT_WIDTH;
  localparam int PW  = CW + frda_pkg::AXIS_COMP;  // one product
  localparam int DW  = PW + 2;                    // dot product
  localparam int W   = DW + 12;                   // cordic datapath, guard + growth
  localparam int ZW  = frda_pkg::ANGLE_WIDTH;
  localparam int OW  = frda_pkg::OUT_WIDTH;
  localparam int N   = CORDIC_STAGES;
  localparam int LAT = 2 * N + 7;

  assign busy = 1'b0;

  // configuration registers
  logic [frda_pkg::AXIS_WIDTH-1:0] x_axis;
  logic [frda_pkg::AXIS_WIDTH-1:0] y_axis;
  logic [frda_pkg::AXIS_WIDTH-1:0] z_axis;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_axis <= frda_pkg::X_AXIS_RESET;
      y_axis <= frda_pkg::Y_AXIS_RESET;
      z_axis <= frda_pkg::Z_AXIS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        frda_pkg::REG_X_AXIS: x_axis <= wr_data;
        frda_pkg::REG_Y_AXIS: y_axis <= wr_data;
        frda_pkg::REG_Z_AXIS: z_axis <= wr_data;
        default: ;
      endcase
    end
  end

  // stage 0: input register
  logic                 vld0;
  logic signed [CW-1:0] v0 [0:2];

  always_ff @(posedge clk) begin
    if (rst) vld0 <= 1'b0;
    else vld0 <= start && !busy;
  end

  always_ff @(posedge clk) begin
    v0[0] <= vec_x;
    v0[1] <= vec_y;
    v0[2] <= vec_z;
  end

  // stage 1: nine component products
  logic                 vld1;
  logic signed [PW-1:0] pa [0:2];
  logic signed [PW-1:0] pb [0:2];
  logic signed [PW-1:0] pc [0:2];

  always_ff @(posedge clk) begin
    if (rst) vld1 <= 1'b0;
    else vld1 <= vld0;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pa[k] <= PW'(v0[k] * frda_pkg::axis_comp(x_axis, k));
      pb[k] <= PW'(v0[k] * frda_pkg::axis_comp(y_axis, k));
      pc[k] <= PW'(v0[k] * frda_pkg::axis_comp(z_axis, k));
    end
  end

  // stage 2: dot products
  logic                 vld2;
  logic signed [DW-1:0] dot_a;
  logic signed [DW-1:0] dot_b;
  logic signed [DW-1:0] dot_c;

  always_ff @(posedge clk) begin
    if (rst) vld2 <= 1'b0;
    else vld2 <= vld1;
  end

  always_ff @(posedge clk) begin
    dot_a <= DW'(pa[0]) + DW'(pa[1]) + DW'(pa[2]);
    dot_b <= DW'(pb[0]) + DW'(pb[1]) + DW'(pb[2]);
    dot_c <= DW'(pc[0]) + DW'(pc[1]) + DW'(pc[2]);
  end

  // stage 3: special cases, guard scaling and azimuth pre-rotation
  logic signed [W-1:0]  a_s;
  logic signed [W-1:0]  b_s;
  logic signed [W-1:0]  c_s;
  logic signed [W-1:0]  px;
  logic signed [W-1:0]  py;
  logic signed [ZW-1:0] pz;

  assign a_s = W'(dot_a) <<< frda_pkg::GUARD_BITS;
  assign b_s = W'(dot_b) <<< frda_pkg::GUARD_BITS;
  assign c_s = W'(dot_c) <<< frda_pkg::GUARD_BITS;

  always_comb begin
    px = a_s;
    py = b_s;
    pz = '0;
    if (a_s[W-1]) begin
      if (!b_s[W-1]) begin
        px = b_s;
        py = -a_s;
        pz = frda_pkg::QUARTER_TURN;
      end else begin
        px = -b_s;
        py = a_s;
        pz = -frda_pkg::QUARTER_TURN;
      end
    end
  end

  // azimuth cordic chain; side data rides alongside each stage
  localparam int SB1 = 4 + 2 * W;  // degen, on-z-neg, b zero, a neg, c, |a|

  logic                 vld_p [0:N];
  logic [SB1-1:0]       sb_p  [0:N];
  logic signed [W-1:0]  xp    [0:N];
  logic signed [W-1:0]  yp    [0:N];
  logic signed [ZW-1:0] zp    [0:N];

  always_ff @(posedge clk) begin
    if (rst) vld_p[0] <= 1'b0;
    else vld_p[0] <= vld2;
  end

  always_ff @(posedge clk) begin
    xp[0]   <= px;
    yp[0]   <= py;
    zp[0]   <= pz;
    // degenerate when a and b vanish; polar is pi only for negative c
    sb_p[0] <= {(dot_a == '0) && (dot_b == '0),
                dot_c[DW-1],
                dot_b == '0,
                dot_a[DW-1],
                c_s,
                dot_a[DW-1] ? -a_s : a_s};
  end

  for (genvar k = 0; k < N; k++) begin : g_phi
    frda_cordic_stage #(.W(W), .ZW(ZW), .SHIFT(k)) u_stage (
      .clk   (clk),
      .x_in  (xp[k]),
      .y_in  (yp[k]),
      .z_in  (zp[k]),
      .x_out (xp[k+1]),
      .y_out (yp[k+1]),
      .z_out (zp[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) vld_p[k+1] <= 1'b0;
      else vld_p[k+1] <= vld_p[k];
    end

    always_ff @(posedge clk) begin
      sb_p[k+1] <= sb_p[k];
    end
  end

  // gain stage 1: azimuth rounding, clamp and b-zero override, split gain multiply
  logic                 p_degen;
  logic                 p_zneg;
  logic                 p_bzero;
  logic                 p_aneg;
  logic signed [W-1:0]  p_c;
  logic signed [W-1:0]  p_absa;
  logic signed [ZW-1:0] phi_round;
  logic signed [W-16:0] mag_hi;

  assign {p_degen, p_zneg, p_bzero, p_aneg, p_c, p_absa} = sb_p[N];
  assign phi_round = (zp[N] + frda_pkg::ROUND_HALF) >>> 16;
  assign mag_hi    = (W-15)'(xp[N] >>> frda_pkg::GAIN_SHIFT);

  logic                 vld_g1;
  logic                 g1_degen;
  logic                 g1_zneg;
  logic                 g1_bzero;
  logic signed [W-1:0]  g1_c;
  logic signed [W-1:0]  g1_absa;
  logic signed [OW-1:0] g1_phi;
  logic signed [W:0]    g1_hi;
  logic [31:0]          g1_lo;

  always_ff @(posedge clk) begin
    if (rst) vld_g1 <= 1'b0;
    else vld_g1 <= vld_p[N];
  end

  always_ff @(posedge clk) begin
    g1_degen <= p_degen;
    g1_zneg  <= p_zneg;
    g1_bzero <= p_bzero;
    g1_c     <= p_c;
    g1_absa  <= p_absa;
    g1_hi    <= (W+1)'(mag_hi * $signed({1'b0, frda_pkg::GAIN_INV}));
    g1_lo    <= 32'(xp[N][15:0] * frda_pkg::GAIN_INV[15:0]);
    if (p_bzero) begin
      g1_phi <= p_aneg ? OW'(frda_pkg::PHI_MIN) : '0;
    end else if (phi_round > frda_pkg::PHI_MAX) begin
      g1_phi <= OW'(frda_pkg::PHI_MAX);
    end else if (phi_round < frda_pkg::PHI_MIN) begin
      g1_phi <= OW'(frda_pkg::PHI_MIN);
    end else begin
      g1_phi <= OW'(phi_round);
    end
  end

  // gain stage 2: radius and polar pre-rotation
  logic signed [W-1:0]  radius;
  logic signed [W-1:0]  tx;
  logic signed [W-1:0]  ty;
  logic signed [ZW-1:0] tz;

  assign radius = g1_bzero ? g1_absa
                           : W'(g1_hi + $signed({1'b0, g1_lo[31:16]}));

  always_comb begin
    tx = g1_c;
    ty = radius;
    tz = '0;
    if (g1_c[W-1]) begin
      if (!radius[W-1]) begin
        tx = radius;
        ty = -g1_c;
        tz = frda_pkg::QUARTER_TURN;
      end else begin
        tx = -radius;
        ty = g1_c;
        tz = -frda_pkg::QUARTER_TURN;
      end
    end
  end

  // polar cordic chain
  localparam int SB2 = OW + 2;  // azimuth, degen, on-z-neg

  logic                 vld_t [0:N];
  logic [SB2-1:0]       sb_t  [0:N];
  logic signed [W-1:0]  xt    [0:N];
  logic signed [W-1:0]  yt    [0:N];
  logic signed [ZW-1:0] zt    [0:N];

  always_ff @(posedge clk) begin
    if (rst) vld_t[0] <= 1'b0;
    else vld_t[0] <= vld_g1;
  end

  always_ff @(posedge clk) begin
    xt[0]   <= tx;
    yt[0]   <= ty;
    zt[0]   <= tz;
    sb_t[0] <= {g1_phi, g1_degen, g1_zneg};
  end

  for (genvar k = 0; k < N; k++) begin : g_theta
    frda_cordic_stage #(.W(W), .ZW(ZW), .SHIFT(k)) u_stage (
      .clk   (clk),
      .x_in  (xt[k]),
      .y_in  (yt[k]),
      .z_in  (zt[k]),
      .x_out (xt[k+1]),
      .y_out (yt[k+1]),
      .z_out (zt[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) vld_t[k+1] <= 1'b0;
      else vld_t[k+1] <= vld_t[k];
    end

    always_ff @(posedge clk) begin
      sb_t[k+1] <= sb_t[k];
    end
  end

  // output stage: polar rounding, clamp and degenerate override
  logic signed [OW-1:0] t_phi;
  logic                 t_degen;
  logic                 t_zneg;
  logic signed [ZW-1:0] theta_round;

  assign {t_phi, t_degen, t_zneg} = sb_t[N];
  assign theta_round = (zt[N] + frda_pkg::ROUND_HALF) >>> 16;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vld_t[N];
  end

  always_ff @(posedge clk) begin
    degenerate <= t_degen;
    if (t_degen) begin
      polar_angle <= t_zneg ? frda_pkg::PI_CODE : '0;
      azimuth     <= '0;
    end else begin
      azimuth <= t_phi;
      if (theta_round[ZW-1]) begin
        polar_angle <= '0;
      end else if (theta_round > frda_pkg::THETA_MAX) begin
        polar_angle <= frda_pkg::PI_CODE;
      end else begin
        polar_angle <= OW'(theta_round);
      end
    end
  end

`ifndef ASSERT_OFF
  // every result traces back to an earlier accepted beat
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without matching input beat");

  // no result on the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> !done)
    else $error("result right after reset");

  // a degenerate result carries zero azimuth
  a_degen_azimuth: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (azimuth == '0))
    else $error("degenerate result with nonzero azimuth");

  // polar angle stays within [0, pi]
  a_polar_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (polar_angle <= frda_pkg::PI_CODE))
    else $error("polar angle out of range");
`endif

endmodule
`default_nettype wire
